### design/symop_power_reduce_core_defines.svh
// Assertion macros for the symmetry operation power reduction block.
// Uses the clk and rst names of the module that includes it.
`ifndef SYMOP_POWER_REDUCE_CORE_DEFINES_SVH
`define SYMOP_POWER_REDUCE_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define SPR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define SPR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SPR_ASSERT_IMP(label, ante, cons, msg)
`define SPR_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

### design/spr_pkg.sv
// Shared widths, operation codes and constants for the power reduction block.
// No dependencies.
package spr_pkg;

  localparam int MAX_ORDER     = 255;
  localparam int EXPONENT_BITS = 16;

  localparam int TYPE_W   = 3;
  localparam int ORIENT_W = 2;
  localparam int ORDER_W  = 8;
  localparam int POWER_W  = 9;
  localparam int EXP_W    = 16;
  localparam int PROD_W   = POWER_W + EXP_W;
  localparam int DIV_W    = ORDER_W + 1;
  localparam int CNT_W    = $clog2(PROD_W + 1);

  typedef logic [TYPE_W-1:0] op_code_t;

  localparam op_code_t OP_IDENT    = 3'd0;
  localparam op_code_t OP_PROPER   = 3'd1;
  localparam op_code_t OP_IMPROPER = 3'd2;
  localparam op_code_t OP_REFLECT  = 3'd3;
  localparam op_code_t OP_INVERT   = 3'd4;

  localparam logic [ORDER_W-1:0] MAX_ORDER_C = ORDER_W'(MAX_ORDER);
  localparam logic [EXP_W-1:0]   EXP_MASK    = EXP_W'((64'd1 << EXPONENT_BITS) - 64'd1);

endpackage

### design/spr_in_if.sv
// Input channel: one symmetry operation and exponent per transfer.
// Depends on spr_pkg.
interface spr_in_if;
  import spr_pkg::*;

  logic                valid;
  logic                ready;
  logic [TYPE_W-1:0]   op_type;
  logic [ORIENT_W-1:0] orientation;
  logic [ORDER_W-1:0]  order;
  logic [POWER_W-1:0]  power_in;
  logic [EXP_W-1:0]    exponent;

  modport source (output valid, op_type, orientation, order, power_in, exponent,
                  input ready);
  modport sink (input valid, op_type, orientation, order, power_in, exponent,
                output ready);
endinterface

### design/spr_out_if.sv
// Output channel: one reduced symmetry operation per transfer.
// Depends on spr_pkg.
interface spr_out_if;
  import spr_pkg::*;

  logic                valid;
  logic                ready;
  logic [TYPE_W-1:0]   out_type;
  logic [ORDER_W-1:0]  out_order;
  logic [POWER_W-1:0]  out_power;
  logic [ORIENT_W-1:0] out_orientation;

  modport source (output valid, out_type, out_order, out_power, out_orientation,
                  input ready);
  modport sink (input valid, out_type, out_order, out_power, out_orientation,
                output ready);
endinterface

### design/symop_power_reduce_core.sv
// Symmetry operation power reduction core: sequencer around one shared divider.
// Depends on spr_pkg, spr_in_if, spr_out_if and symop_power_reduce_core_defines.svh.
//
// Raises one point-group operation to a non-negative exponent and returns its
// canonical form. One operation is in flight at a time; req.ready is high only
// while the core is idle. Identity, reflection, inversion and unknown types go
// straight from the transfer to S_FIN. A rotation of non-zero order first forms
// p*e mod 2n; unless the power reduces to identity, it then runs Euclid's gcd of n
// and the reduced power, at most 11 Euclid steps for 8-bit orders, and divides
// the order and the power by the gcd. An improper power may then be re-reduced.
// All divisions share the single restoring divider, which retires one quotient
// bit per cycle. S_FIN holds the result until the output register is free. A
// finished result waits in the output register while the next transfer is taken.
`include "symop_power_reduce_core_defines.svh"

module symop_power_reduce_core (
  input  logic      clk,
  input  logic      rst,
  spr_in_if.sink    req,
  spr_out_if.source rsp
);
  import spr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_DIVR, S_QCHK, S_GCD, S_DIVO, S_DIVP, S_POST, S_ADJ, S_FIX, S_FIN
  } state_t;

  state_t              state;
  op_code_t            typ;
  logic [ORIENT_W-1:0] orient;
  logic [ORDER_W-1:0]  n;
  logic [POWER_W-1:0]  p;
  logic [EXP_W-1:0]    e;
  logic [DIV_W-1:0]    r;
  logic [ORDER_W-1:0]  q;
  op_code_t            rt;
  logic [ORDER_W-1:0]  ro;
  logic [POWER_W-1:0]  rp;

  // shared divider
  logic [PROD_W-1:0]   dq;
  logic [DIV_W-1:0]    rem;
  logic [DIV_W-1:0]    dvs;
  logic [CNT_W-1:0]    cnt;

  logic                ovalid;
  op_code_t            o_type;
  logic [ORDER_W-1:0]  o_order;
  logic [POWER_W-1:0]  o_power;
  logic [ORIENT_W-1:0] o_orient;

  logic [DIV_W:0]      rem_sh;
  logic                div_ge;
  logic [DIV_W-1:0]    rem_nx;
  logic [PROD_W-1:0]   dq_nx;
  logic                div_last;
  logic [ORDER_W-1:0]  q_c;
  logic [ORDER_W-1:0]  n_in;
  logic [POWER_W-1:0]  p_in;
  logic [EXP_W-1:0]    e_in;
  logic                o_load;

  localparam logic [PROD_W-DIV_W-1:0] LOW_ZERO = '0;
  localparam logic [CNT_W-1:0]        LONG_STEPS  = CNT_W'(PROD_W);
  localparam logic [CNT_W-1:0]        SHORT_STEPS = CNT_W'(DIV_W);

  always_comb begin
    rem_sh   = {rem, dq[PROD_W-1]};
    div_ge   = rem_sh >= {1'b0, dvs};
    rem_nx   = div_ge ? DIV_W'(rem_sh - {1'b0, dvs}) : rem_sh[DIV_W-1:0];
    dq_nx    = {dq[PROD_W-2:0], div_ge};
    div_last = cnt == CNT_W'(1);
    q_c      = (r >= {1'b0, n}) ? ORDER_W'(r - {1'b0, n}) : r[ORDER_W-1:0];
    n_in     = (req.order > MAX_ORDER_C) ? MAX_ORDER_C : req.order;
    p_in     = (req.power_in == '0) ? POWER_W'(1) : req.power_in;
    e_in     = req.exponent & EXP_MASK;
    o_load   = (state == S_FIN) && (!ovalid || rsp.ready);
  end

  assign req.ready           = state == S_IDLE;
  assign rsp.valid           = ovalid;
  assign rsp.out_type        = o_type;
  assign rsp.out_order       = o_order;
  assign rsp.out_power       = o_power;
  assign rsp.out_orientation = o_orient;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      ovalid <= 1'b0;
    end else begin
      if (o_load) begin
        ovalid <= 1'b1;
      end else if (rsp.ready) begin
        ovalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            typ    <= req.op_type;
            orient <= req.orientation;
            n      <= n_in;
            p      <= p_in;
            e      <= e_in;
            ro     <= '0;
            rp     <= POWER_W'(1);
            if (req.op_type == OP_PROPER || req.op_type == OP_IMPROPER) begin
              state <= S_MUL;
            end else begin
              if ((req.op_type == OP_REFLECT || req.op_type == OP_INVERT) && e_in[0]) begin
                rt <= req.op_type;
              end else begin
                rt <= OP_IDENT;
              end
              state <= S_FIN;
            end
          end
        end
        S_MUL: begin
          if (n == '0) begin
            r     <= '0;
            state <= S_QCHK;
          end else begin
            dq    <= PROD_W'(p) * PROD_W'(e);
            rem   <= '0;
            dvs   <= {n, 1'b0};
            cnt   <= LONG_STEPS;
            state <= S_DIVR;
          end
        end
        S_DIVR: begin
          dq  <= dq_nx;
          rem <= rem_nx;
          cnt <= cnt - CNT_W'(1);
          if (div_last) begin
            r     <= rem_nx;
            state <= S_QCHK;
          end
        end
        S_QCHK: begin
          q <= q_c;
          if (q_c == '0) begin
            rt    <= OP_IDENT;
            ro    <= '0;
            rp    <= POWER_W'(1);
            state <= S_POST;
          end else begin
            dq    <= {1'b0, n, LOW_ZERO};
            rem   <= '0;
            dvs   <= {1'b0, q_c};
            cnt   <= SHORT_STEPS;
            state <= S_GCD;
          end
        end
        S_GCD: begin
          if (div_last) begin
            rem <= '0;
            cnt <= SHORT_STEPS;
            if (rem_nx == '0) begin
              // dvs now holds the gcd
              dq    <= {1'b0, n, LOW_ZERO};
              state <= S_DIVO;
            end else begin
              dq  <= {dvs, LOW_ZERO};
              dvs <= rem_nx;
            end
          end else begin
            dq  <= dq_nx;
            rem <= rem_nx;
            cnt <= cnt - CNT_W'(1);
          end
        end
        S_DIVO: begin
          if (div_last) begin
            ro    <= dq_nx[ORDER_W-1:0];
            dq    <= {1'b0, q, LOW_ZERO};
            rem   <= '0;
            cnt   <= SHORT_STEPS;
            state <= S_DIVP;
          end else begin
            dq  <= dq_nx;
            rem <= rem_nx;
            cnt <= cnt - CNT_W'(1);
          end
        end
        S_DIVP: begin
          dq  <= dq_nx;
          rem <= rem_nx;
          cnt <= cnt - CNT_W'(1);
          if (div_last) begin
            rp    <= dq_nx[POWER_W-1:0];
            rt    <= OP_PROPER;
            state <= S_POST;
          end
        end
        S_POST: begin
          priority if (typ != OP_IMPROPER) begin
            state <= S_FIN;
          end else if (rt == OP_IDENT && e == '0) begin
            state <= S_FIN;
          end else if (rt == OP_IDENT && n[0] && r == {1'b0, n}) begin
            rt    <= OP_REFLECT;
            ro    <= '0;
            rp    <= POWER_W'(1);
            state <= S_FIN;
          end else if (r > {1'b0, n} && n[0] && r[0]) begin
            // odd order, odd r past n: advance by n, reduce mod twice the reduced order
            dq    <= {POWER_W'(rp + {1'b0, n}), LOW_ZERO};
            rem   <= '0;
            dvs   <= {ro, 1'b0};
            cnt   <= SHORT_STEPS;
            state <= S_ADJ;
          end else begin
            state <= S_FIX;
          end
        end
        S_ADJ: begin
          dq  <= dq_nx;
          rem <= rem_nx;
          cnt <= cnt - CNT_W'(1);
          if (div_last) begin
            rp    <= rem_nx;
            state <= S_FIX;
          end
        end
        S_FIX: begin
          if (r[0] && ro == ORDER_W'(2)) begin
            rt <= OP_INVERT;
            ro <= '0;
            rp <= POWER_W'(1);
          end else if (r[0]) begin
            rt <= OP_IMPROPER;
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (o_load) begin
            o_type   <= rt;
            o_order  <= ro;
            o_power  <= rp;
            o_orient <= orient;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `SPR_ASSERT_IMP(a_plain_result_fields, rsp.valid && rsp.out_type != OP_PROPER && rsp.out_type != OP_IMPROPER, rsp.out_order == '0 && rsp.out_power == POWER_W'(1), "non-rotation result with order or power set")
  `SPR_ASSERT_IMP(a_proper_power_below_order, rsp.valid && rsp.out_type == OP_PROPER, rsp.out_power < POWER_W'(rsp.out_order), "proper rotation power not below its order")
  `SPR_ASSERT_IMP(a_div_rem_below_divisor, state == S_DIVR || state == S_GCD || state == S_DIVO || state == S_DIVP || state == S_ADJ, rem < dvs && dvs != '0, "divider remainder out of range")
  `SPR_ASSERT_NXT(a_transfer_leaves_idle, req.valid && req.ready, state != S_IDLE, "transfer taken but sequencer stayed idle")

endmodule
